>>> rtl/aiffcp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aiffcp_pkg: shared constants and types for the AIFF COMM chunk parser
// Tags of the file and chunk headers, length limits, status codes and the
// result word carried on the output channel.
// ----------------------------------------------------------------------------
package aiffcp_pkg;

  // four-character tags, first character in the top byte
  localparam logic [31:0] TAG_FORM = 32'h464F524D;
  localparam logic [31:0] TAG_AIFF = 32'h41494646;
  localparam logic [31:0] TAG_COMM = 32'h434F4D4D;

  // byte positions inside the file header, chunk header and COMM body
  localparam logic [4:0] TAG_BYTES     = 5'd4;
  localparam logic [4:0] AIFF_FIRST    = 5'd8;
  localparam logic [4:0] HDR_LAST_IDX  = 5'd11;
  localparam logic [4:0] LEN_LAST_IDX  = 5'd7;
  localparam logic [4:0] FIELDS_BYTES  = 5'd8;
  localparam logic [4:0] COMM_LAST_IDX = 5'd17;

  // smallest COMM chunk body that carries all fields
  localparam logic [31:0] COMM_MIN_LEN = 32'd18;

  // result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NOT_AIFF = 2'd1;
  localparam logic [1:0] STATUS_NO_COMM  = 2'd2;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] channel_count;
    logic [15:0] sample_bits;
    logic [31:0] frame_count;
  } result_t;

  // pick one character of a tag, index 0 is the first character
  function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] idx);
    logic [7:0] sel;
    unique case (idx)
      2'd0: sel = tag[31:24];
      2'd1: sel = tag[23:16];
      2'd2: sel = tag[15:8];
      default: sel = tag[7:0];
    endcase
    return sel;
  endfunction

endpackage

>>> rtl/aiff_comm_chunk_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aiff_comm_chunk_parser: AIFF header check and COMM chunk field capture
// Parses an AIFF file one byte per word and reports the COMM fields at the
// end of the file.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one file byte per word (in_data_byte) with
//   in_end_of_file set on the last byte. Every byte is parsed in the cycle it
//   is accepted, so the block takes one word per clock cycle, back to back, while in_ready is high.
//   Only the last byte of a file yields a word on the output channel: status
//   (ok, not AIFF, no usable COMM) and the channels, sample bits and frames of
//   the last complete COMM chunk. That word goes to the output register, or
//   to the skid entry if the register still holds an untaken result. The parser
//   restarts with the last byte, so the next byte begins a new file with no gap.
//   The output side holds a result register and one skid entry; the input
//   stays ready while a result waits and only stalls when both hold a file's
//   result that the receiver has not taken. The rate is set by the single
//   byte-wide update of the parse state, one byte per cycle.
//   Reset (rst_n low, synchronous) empties the output side and returns the
//   parser to the start of a file with all captured fields zero.
// ----------------------------------------------------------------------------
module aiff_comm_chunk_parser
  import aiffcp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_file,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [15:0] out_channel_count,
  output logic [15:0] out_sample_bits,
  output logic [31:0] out_frame_count
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_CHUNK_HDR,
    PH_COMM,
    PH_SKIP,
    PH_BAD
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [4:0]  byte_index_r, byte_index_nxt;
  logic        header_good_r, header_good_nxt;
  logic        chunk_is_comm_r, chunk_is_comm_nxt;
  logic [31:0] chunk_length_r, chunk_length_nxt;
  logic [32:0] skip_remaining_r, skip_remaining_nxt;
  logic [63:0] pending_r, pending_nxt;
  logic [15:0] channels_r, channels_nxt;
  logic [15:0] bits_r, bits_nxt;
  logic [31:0] frames_r, frames_nxt;

  logic [31:0] new_length;
  logic [32:0] padded_new;
  logic [32:0] padded_cur;
  logic [32:0] comm_rest;
  logic [7:0]  tag_expect;
  logic        in_fire;
  logic        out_fire;
  result_t     result;
  result_t     out_r;
  result_t     skid_r;
  logic        out_valid_r;
  logic        skid_valid_r;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid_r && out_ready;
  assign in_ready = !skid_valid_r;

  // length and padding arithmetic
  assign new_length = {chunk_length_r[23:0], in_data_byte};
  assign padded_new = {1'b0, new_length} + {32'd0, new_length[0]};
  assign padded_cur = {1'b0, chunk_length_r} + {32'd0, chunk_length_r[0]};
  assign comm_rest  = padded_cur - {1'b0, COMM_MIN_LEN};

  // next parse state for the byte on the input
  always_comb begin
    phase_nxt          = phase_r;
    byte_index_nxt     = byte_index_r;
    header_good_nxt    = header_good_r;
    chunk_is_comm_nxt  = chunk_is_comm_r;
    chunk_length_nxt   = chunk_length_r;
    skip_remaining_nxt = skip_remaining_r;
    pending_nxt        = pending_r;
    channels_nxt       = channels_r;
    bits_nxt           = bits_r;
    frames_nxt         = frames_r;
    tag_expect         = 8'd0;
    unique case (phase_r)
      PH_HEADER: begin
        if (byte_index_r < TAG_BYTES) begin
          tag_expect = tag_byte(TAG_FORM, byte_index_r[1:0]);
          if (in_data_byte != tag_expect) header_good_nxt = 1'b0;
        end else if (byte_index_r >= AIFF_FIRST) begin
          tag_expect = tag_byte(TAG_AIFF, byte_index_r[1:0]);
          if (in_data_byte != tag_expect) header_good_nxt = 1'b0;
        end
        if (byte_index_r >= HDR_LAST_IDX) begin
          byte_index_nxt = 5'd0;
          phase_nxt      = header_good_nxt ? PH_CHUNK_HDR : PH_BAD;
        end else begin
          byte_index_nxt = byte_index_r + 5'd1;
        end
      end
      PH_CHUNK_HDR: begin
        if (byte_index_r < TAG_BYTES) begin
          tag_expect = tag_byte(TAG_COMM, byte_index_r[1:0]);
          chunk_is_comm_nxt = (byte_index_r == 5'd0 || chunk_is_comm_r) &&
                              (in_data_byte == tag_expect);
          byte_index_nxt = byte_index_r + 5'd1;
        end else begin
          chunk_length_nxt = new_length;
          if (byte_index_r >= LEN_LAST_IDX) begin
            byte_index_nxt = 5'd0;
            if (chunk_is_comm_r && new_length >= COMM_MIN_LEN) begin
              phase_nxt   = PH_COMM;
              pending_nxt = 64'd0;
            end else begin
              skip_remaining_nxt = padded_new;
              phase_nxt          = (padded_new == 33'd0) ? PH_CHUNK_HDR : PH_SKIP;
            end
          end else begin
            byte_index_nxt = byte_index_r + 5'd1;
          end
        end
      end
      PH_COMM: begin
        if (byte_index_r < FIELDS_BYTES) pending_nxt = {pending_r[55:0], in_data_byte};
        if (byte_index_r >= COMM_LAST_IDX) begin
          channels_nxt       = pending_r[63:48];
          frames_nxt         = pending_r[47:16];
          bits_nxt           = pending_r[15:0];
          skip_remaining_nxt = comm_rest;
          byte_index_nxt     = 5'd0;
          phase_nxt          = (comm_rest == 33'd0) ? PH_CHUNK_HDR : PH_SKIP;
        end else begin
          byte_index_nxt = byte_index_r + 5'd1;
        end
      end
      PH_SKIP: begin
        if (skip_remaining_r != 33'd0) skip_remaining_nxt = skip_remaining_r - 33'd1;
        if (skip_remaining_nxt == 33'd0) begin
          phase_nxt      = PH_CHUNK_HDR;
          byte_index_nxt = 5'd0;
        end
      end
      PH_BAD: begin
        phase_nxt = PH_BAD;
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase
  end

  // result word for a final byte
  always_comb begin
    if (phase_nxt == PH_HEADER || phase_nxt == PH_BAD) begin
      result.status = STATUS_NOT_AIFF;
    end else if (channels_nxt == 16'd0 || bits_nxt == 16'd0) begin
      result.status = STATUS_NO_COMM;
    end else begin
      result.status = STATUS_OK;
    end
    result.channel_count = channels_nxt;
    result.sample_bits   = bits_nxt;
    result.frame_count   = frames_nxt;
  end

  // parse state, cleared after the final byte of a file
  always_ff @(posedge clk) begin
    if (!rst_n || (in_fire && in_end_of_file)) begin
      phase_r          <= PH_HEADER;
      byte_index_r     <= 5'd0;
      header_good_r    <= 1'b1;
      chunk_is_comm_r  <= 1'b0;
      chunk_length_r   <= 32'd0;
      skip_remaining_r <= 33'd0;
      pending_r        <= 64'd0;
      channels_r       <= 16'd0;
      bits_r           <= 16'd0;
      frames_r         <= 32'd0;
    end else if (in_fire) begin
      phase_r          <= phase_nxt;
      byte_index_r     <= byte_index_nxt;
      header_good_r    <= header_good_nxt;
      chunk_is_comm_r  <= chunk_is_comm_nxt;
      chunk_length_r   <= chunk_length_nxt;
      skip_remaining_r <= skip_remaining_nxt;
      pending_r        <= pending_nxt;
      channels_r       <= channels_nxt;
      bits_r           <= bits_nxt;
      frames_r         <= frames_nxt;
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_ready) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (in_fire && in_end_of_file) begin
      if (!out_valid_r || out_ready) begin
        out_r       <= result;
        out_valid_r <= 1'b1;
      end else begin
        skid_r       <= result;
        skid_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_r.status;
  assign out_channel_count = out_r.channel_count;
  assign out_sample_bits   = out_r.sample_bits;
  assign out_frame_count   = out_r.frame_count;

  // skid entry is only used behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry holds a word while the output register is empty");

  // byte counter stays inside the current header or body
  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_HEADER || byte_index_r <= HDR_LAST_IDX) &&
    (phase_r != PH_CHUNK_HDR || byte_index_r <= LEN_LAST_IDX) &&
    (phase_r != PH_COMM || byte_index_r <= COMM_LAST_IDX))
    else $error("byte index beyond the current field");

  // a body being skipped always has bytes left
  a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_SKIP) |-> (skip_remaining_r != 33'd0))
    else $error("skip phase with nothing left to skip");

  // the final byte restarts the parser
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_end_of_file) |=> (phase_r == PH_HEADER && byte_index_r == 5'd0 &&
                                    channels_r == 16'd0))
    else $error("parser not restarted after the final byte");

  // an ok status always carries usable fields
  a_ok_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status == STATUS_OK) |->
      (out_r.channel_count != 16'd0 && out_r.sample_bits != 16'd0))
    else $error("ok status with zero channels or sample bits");

endmodule

>>> verif/aiff_comm_chunk_parser_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aiff_comm_chunk_parser_test: byte-stream test of the AIFF COMM chunk parser
// Builds AIFF files byte by byte, from hand-written corner cases and from
// random mostly well-formed files with random content, and feeds them through
// a valid/ready driver. A parse model updated on every accepted byte predicts
// the end-of-file report, and a monitor checks every report field by field.
// Phases vary sender gaps and receiver stalls, and one long receiver hold-off
// backs up the output side until the input stalls.
// ----------------------------------------------------------------------------
module aiff_comm_chunk_parser_test
  import aiffcp_pkg::*;
();

  localparam int RANDOM_BYTES  = 1200;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 20;
  localparam int RUN_LIMIT_NS  = 6_000_000;

  typedef enum logic [2:0] {
    STEP_FILE_HDR,
    STEP_CHUNK_HDR,
    STEP_COMM_BODY,
    STEP_SKIP_BODY,
    STEP_BAD_FILE
  } parse_step_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eof;
  } file_word_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_end_of_file = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [15:0] out_channel_count;
  logic [15:0] out_sample_bits;
  logic [31:0] out_frame_count;

  // stimulus and expectations
  file_word_t  file_words[$];
  logic [7:0]  file_buf[$];
  result_t     expected_reports[$];
  int          words_queued = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          failed = 1'b0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  logic        hold_active = 1'b0;

  // parse model state
  parse_step_t step;
  logic [4:0]  pos;
  logic        hdr_ok;
  logic        is_comm;
  logic [31:0] chunk_len;
  logic [32:0] skip_left;
  logic [63:0] field_shift;
  logic [15:0] chans;
  logic [15:0] bits;
  logic [31:0] frames;

  aiff_comm_chunk_parser dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_end_of_file    (in_end_of_file),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_channel_count (out_channel_count),
    .out_sample_bits   (out_sample_bits),
    .out_frame_count   (out_frame_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ------------------------------------------------------------------------
  // parse model
  // ------------------------------------------------------------------------
  function automatic void clear_parse_state();
    step        = STEP_FILE_HDR;
    pos         = 5'd0;
    hdr_ok      = 1'b1;
    is_comm     = 1'b0;
    chunk_len   = 32'd0;
    skip_left   = 33'd0;
    field_shift = 64'd0;
    chans       = 16'd0;
    bits        = 16'd0;
    frames      = 32'd0;
  endfunction

  function automatic logic [7:0] tag_char(logic [31:0] tag, logic [4:0] idx);
    return tag[8 * (3 - idx[1:0]) +: 8];
  endfunction

  function automatic void start_skip(logic [32:0] amount);
    skip_left = amount;
    pos       = 5'd0;
    step      = (amount == 33'd0) ? STEP_CHUNK_HDR : STEP_SKIP_BODY;
  endfunction

  function automatic void consume_byte(logic [7:0] b);
    logic [32:0] padded;
    padded = {1'b0, chunk_len} + chunk_len[0];
    case (step)
      STEP_FILE_HDR: begin
        if (pos < TAG_BYTES) begin
          if (b != tag_char(TAG_FORM, pos)) hdr_ok = 1'b0;
        end else if (pos >= AIFF_FIRST) begin
          if (b != tag_char(TAG_AIFF, pos - AIFF_FIRST)) hdr_ok = 1'b0;
        end
        if (pos >= HDR_LAST_IDX) begin
          pos  = 5'd0;
          step = hdr_ok ? STEP_CHUNK_HDR : STEP_BAD_FILE;
        end else begin
          pos++;
        end
      end
      STEP_CHUNK_HDR: begin
        if (pos < TAG_BYTES) begin
          if (pos == 5'd0) is_comm = 1'b1;
          if (b != tag_char(TAG_COMM, pos)) is_comm = 1'b0;
          pos++;
        end else begin
          chunk_len = {chunk_len[23:0], b};
          if (pos >= LEN_LAST_IDX) begin
            if (is_comm && chunk_len >= COMM_MIN_LEN) begin
              step        = STEP_COMM_BODY;
              pos         = 5'd0;
              field_shift = 64'd0;
            end else begin
              start_skip({1'b0, chunk_len} + chunk_len[0]);
            end
          end else begin
            pos++;
          end
        end
      end
      STEP_COMM_BODY: begin
        if (pos < FIELDS_BYTES) field_shift = {field_shift[55:0], b};
        if (pos >= COMM_LAST_IDX) begin
          chans  = field_shift[63:48];
          frames = field_shift[47:16];
          bits   = field_shift[15:0];
          start_skip(padded - 33'(COMM_MIN_LEN));
        end else begin
          pos++;
        end
      end
      STEP_SKIP_BODY: begin
        if (skip_left > 33'd0) skip_left--;
        if (skip_left == 33'd0) begin
          step = STEP_CHUNK_HDR;
          pos  = 5'd0;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic result_t file_report();
    result_t r;
    if (step == STEP_FILE_HDR || step == STEP_BAD_FILE) r.status = STATUS_NOT_AIFF;
    else if (chans == 16'd0 || bits == 16'd0) r.status = STATUS_NO_COMM;
    else r.status = STATUS_OK;
    r.channel_count = chans;
    r.sample_bits   = bits;
    r.frame_count   = frames;
    return r;
  endfunction

  // ------------------------------------------------------------------------
  // file building
  // ------------------------------------------------------------------------
  function automatic void put_be32(logic [31:0] v);
    for (int i = 3; i >= 0; i--) file_buf.push_back(v[8 * i +: 8]);
  endfunction

  function automatic void put_be16(logic [15:0] v);
    file_buf.push_back(v[15:8]);
    file_buf.push_back(v[7:0]);
  endfunction

  function automatic void put_random(int n);
    for (int i = 0; i < n; i++) file_buf.push_back(8'($urandom_range(255)));
  endfunction

  function automatic void put_file_header();
    put_be32(TAG_FORM);
    put_be32($urandom);
    put_be32(TAG_AIFF);
  endfunction

  // move the built file to the driver queue, last byte flagged
  function automatic void flush_file();
    file_word_t w;
    if (file_buf.size() == 0) put_random(1);
    foreach (file_buf[i]) begin
      w.data = file_buf[i];
      w.eof  = (i == file_buf.size() - 1);
      file_words.push_back(w);
      words_queued++;
    end
    file_buf.delete();
  endfunction

  function automatic logic [15:0] rand_field16();
    return ($urandom_range(5) == 0) ? 16'd0 : 16'($urandom);
  endfunction

  function automatic void build_random_file();
    int unsigned n_chunks;
    int unsigned kind;
    int unsigned len;
    int unsigned keep;
    logic [31:0] id;
    file_buf.delete();
    if ($urandom_range(9) == 0) begin
      // plain noise
      put_random($urandom_range(1, 30));
    end else begin
      put_file_header();
      if ($urandom_range(14) == 0) file_buf[$urandom_range(11)] = 8'($urandom_range(255));
      n_chunks = $urandom_range(3);
      for (int c = 0; c < n_chunks; c++) begin
        kind = $urandom_range(9);
        if (kind < 5) begin
          // COMM, mostly long enough to carry the fields
          len = ($urandom_range(4) == 0) ? $urandom_range(17) : $urandom_range(18, 24);
          put_be32(TAG_COMM);
          put_be32(len);
          if (len >= COMM_MIN_LEN) begin
            put_be16(rand_field16());
            put_be32($urandom);
            put_be16(rand_field16());
            put_random(len - 8 + (len & 1));
          end else begin
            put_random(len + (len & 1));
          end
        end else if (kind < 9) begin
          // other chunk, often one character away from COMM
          id = $urandom_range(1) ? (TAG_COMM ^ (32'(1 + $urandom_range(254))
                                                << (8 * $urandom_range(3))))
                                 : 32'($urandom);
          len = $urandom_range(7);
          put_be32(id);
          put_be32(len);
          put_random(len + (len & 1));
        end else begin
          // huge chunk cut off by the end of the file
          put_be32($urandom_range(1) ? TAG_COMM : 32'($urandom));
          put_be32($urandom | 32'h0000_0100);
          put_random($urandom_range(25));
          break;
        end
      end
      if ($urandom_range(4) == 0) begin
        keep = $urandom_range(1, file_buf.size());
        while (file_buf.size() > keep) void'(file_buf.pop_back());
      end
    end
    flush_file();
  endfunction

  task automatic wait_inputs_taken();
    while (file_words.size() != 0 || in_valid) @(negedge clk);
  endtask

  // ------------------------------------------------------------------------
  // driver: one file byte per word
  // ------------------------------------------------------------------------
  always @(posedge clk) begin : driver
    file_word_t w;
    if (!rst_n) begin
      in_valid       <= 1'b0;
      in_data_byte   <= 8'd0;
      in_end_of_file <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (file_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        w = file_words.pop_front();
        in_valid       <= 1'b1;
        in_data_byte   <= w.data;
        in_end_of_file <= w.eof;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver ready with random stalls, or held off during the pressure phase
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if (hold_active) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // long receiver hold-off, counted here
  initial begin
    wait (hold_req);
    @(posedge clk);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active <= 1'b0;
    hold_done = 1'b1;
  end

  // ------------------------------------------------------------------------
  // monitor: predict on accepted bytes, check accepted reports
  // ------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    result_t want;
    if (!rst_n) begin
      clear_parse_state();
    end else begin
      if (in_valid && in_ready) begin
        consume_byte(in_data_byte);
        if (in_end_of_file) begin
          expected_reports.push_back(file_report());
          clear_parse_state();
        end
      end
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          $error("report word with no file pending: status %0d", out_status);
          failed = 1'b1;
        end else begin
          want = expected_reports.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            failed = 1'b1;
          end
          if (out_channel_count !== want.channel_count) begin
            $error("channel_count: expected %0d, got %0d",
                   want.channel_count, out_channel_count);
            failed = 1'b1;
          end
          if (out_sample_bits !== want.sample_bits) begin
            $error("sample_bits: expected %0d, got %0d", want.sample_bits, out_sample_bits);
            failed = 1'b1;
          end
          if (out_frame_count !== want.frame_count) begin
            $error("frame_count: expected %0d, got %0d", want.frame_count, out_frame_count);
            failed = 1'b1;
          end
        end
      end
    end
  end

  // run limit
  initial begin
    #(RUN_LIMIT_NS);
    $display("simulation failed");
    $finish;
  end

  // ------------------------------------------------------------------------
  // stimulus sequence
  // ------------------------------------------------------------------------
  initial begin
    int start_words;
    int n_files;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // file cut off inside the header
    put_random(1);
    flush_file();
    // wrong form tag, trailing bytes ignored
    put_be32(TAG_FORM ^ 32'h0000_0001);
    put_be32(32'hFFFF_FFFF);
    put_be32(TAG_AIFF);
    put_random(3);
    flush_file();
    // good header, no chunks at all
    put_be32(TAG_FORM);
    put_be32(32'd0);
    put_be32(TAG_AIFF);
    flush_file();
    // smallest COMM with all-ones fields
    put_file_header();
    put_be32(TAG_COMM);
    put_be32(COMM_MIN_LEN);
    put_be16(16'hFFFF);
    put_be32(32'hFFFF_FFFF);
    put_be16(16'hFFFF);
    put_random(10);
    flush_file();
    // odd COMM with pad, short COMM, odd near-COMM chunk, overriding COMM
    // with zero channels
    put_file_header();
    put_be32(TAG_COMM);
    put_be32(32'd19);
    put_be16(16'd2);
    put_be32(32'd1000);
    put_be16(16'd16);
    put_random(12);
    put_be32(TAG_COMM);
    put_be32(32'd17);
    put_random(18);
    put_be32(TAG_COMM ^ 32'h0000_0001);
    put_be32(32'd1);
    put_random(2);
    put_be32(TAG_COMM);
    put_be32(COMM_MIN_LEN);
    put_be16(16'd0);
    put_be32(32'd5);
    put_be16(16'd8);
    put_random(10);
    flush_file();
    // complete COMM followed by one cut short, which must not commit
    put_file_header();
    put_be32(TAG_COMM);
    put_be32(COMM_MIN_LEN);
    put_be16(16'd1);
    put_be32(32'd44100);
    put_be16(16'd24);
    put_random(10);
    put_be32(TAG_COMM);
    put_be32(32'd20);
    put_be16(16'd7);
    put_random(8);
    flush_file();
    // zero-length chunk, then largest odd length cut short
    put_file_header();
    put_be32(32'h0000_0000);
    put_be32(32'd0);
    put_be32(TAG_COMM ^ 32'hFF00_0000);
    put_be32(32'hFFFF_FFFF);
    put_random(5);
    flush_file();
    // file ends inside a chunk length
    put_file_header();
    put_be32(TAG_COMM);
    put_be16(16'd0);
    flush_file();
    wait_inputs_taken();

    // random files under four idling profiles
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 52;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 52;
        end
        default: begin
          send_idle_pct  = 9;
          recv_stall_pct = 9;
        end
      endcase
      start_words = words_queued;
      n_files = 0;
      while (words_queued - start_words < RANDOM_BYTES / 4 || n_files < 8) begin
        build_random_file();
        n_files++;
      end
      wait_inputs_taken();
    end

    // back up the output side with many short files during a long hold-off
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) begin
      if (i % 10 == 9) build_random_file();
      else begin
        put_random($urandom_range(1, 6));
        flush_file();
      end
    end
    wait (hold_done);
    wait_inputs_taken();

    // let every report come out
    while (expected_reports.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (!failed) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
